>>> sv/assert_macros.svh
// Assertion macros used by the checker file of the band averager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sba_pkg.sv
// Shared constants and helpers for the spectrum band averager.
package sba_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 1'b1;

    // input item kinds, carried on tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_PUSH = 1'b1;

    // depth of the band job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // width rounded up to whole bytes
    function automatic int byte_round(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

>>> sv/sba_queue.sv
// Small register FIFO holding band jobs between the front and the back.
module sba_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    import sba_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_fire, rd_fire;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign wr_fire = wr_en && !full;
    assign rd_fire = rd_en && !empty;

    // pointer and fill tracking
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_fire) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_fire) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({wr_fire, rd_fire})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> sv/sba_front.sv
// Front end: config registers, boundary table, bin accumulation and band detection.
module sba_front #(
    parameter int MAX_BANDS    = 16,
    parameter int MAX_FRAME    = 1024,
    parameter int SAMPLE_WIDTH = 16,
    localparam int BAND_W = $clog2(MAX_BANDS),
    localparam int FS_W   = $clog2(MAX_FRAME + 1),
    localparam int BC_W   = $clog2(MAX_BANDS + 1),
    localparam int CFG_W  = (FS_W > BC_W) ? FS_W : BC_W,
    localparam int SUM_W  = SAMPLE_WIDTH + FS_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    // input items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [BAND_W-1:0]             s_entry,
    input  logic [FS_W-1:0]               s_boundary,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    // band jobs towards the queue
    output logic                          job_push,
    input  logic                          job_full,
    output logic [BAND_W-1:0]             job_band,
    output logic signed [SUM_W-1:0]       job_sum,
    output logic [FS_W-1:0]               job_count,
    output logic                          job_empty,
    output logic                          job_last
);
    import sba_pkg::*;

    localparam int TBL_DEPTH = MAX_BANDS - 1;
    localparam int TIDX_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_SCAN = 2'b10
    } front_state_t;

    front_state_t            state_reg, state_next;
    logic [FS_W-1:0]         frame_size_reg;
    logic [BC_W-1:0]         bucket_count_reg;
    logic [FS_W-1:0]         boundary_reg [TBL_DEPTH];
    logic [FS_W-1:0]         pos_reg, pos_next;
    logic [BAND_W-1:0]       band_reg, band_next;
    logic [FS_W-1:0]         start_reg, start_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;

    logic [FS_W-1:0] fs_eff;
    logic [BC_W-1:0] nb_eff;
    logic [BC_W-1:0] band_ext;
    logic            in_range, band_last, band_empty, tbl_sel, emit, tbl_we;
    logic [FS_W-1:0] tbl_val, stop;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == F_IDLE);

    // effective frame size and band count (zero acts as one, clamp at the maximum)
    always_comb begin
        if (frame_size_reg == '0) begin
            fs_eff = FS_W'(1);
        end else if (frame_size_reg > FS_W'(MAX_FRAME)) begin
            fs_eff = FS_W'(MAX_FRAME);
        end else begin
            fs_eff = frame_size_reg;
        end
        if (bucket_count_reg == '0) begin
            nb_eff = BC_W'(1);
        end else if (bucket_count_reg > BC_W'(MAX_BANDS)) begin
            nb_eff = BC_W'(MAX_BANDS);
        end else begin
            nb_eff = bucket_count_reg;
        end
    end

    // end of the current band and whether it is due
    always_comb begin
        band_ext   = BC_W'(band_reg);
        in_range   = (band_ext < nb_eff);
        band_last  = (BC_W'(band_ext + BC_W'(1)) >= nb_eff);
        tbl_sel    = (band_reg < BAND_W'(TBL_DEPTH));
        tbl_val    = boundary_reg[band_reg[TIDX_W-1:0]];
        if (band_last || !tbl_sel) begin
            stop = fs_eff;
        end else begin
            stop = (tbl_val > fs_eff) ? fs_eff : tbl_val;
        end
        emit       = in_range && (band_last ? (pos_reg >= fs_eff) : (stop <= pos_reg));
        band_empty = (stop <= start_reg);
    end

    assign job_band  = band_reg;
    assign job_sum   = sum_reg;
    assign job_count = pos_reg - start_reg;
    assign job_empty = band_empty;
    assign job_last  = band_last;

    // item acceptance and band walk
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        band_next  = band_reg;
        start_next = start_reg;
        sum_next   = sum_reg;
        tbl_we     = 1'b0;
        job_push   = 1'b0;
        case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    if (s_action == ACT_PUSH) begin
                        sum_next   = sum_reg + SUM_W'(s_sample);
                        pos_next   = pos_reg + FS_W'(1);
                        state_next = F_SCAN;
                    end else if (s_entry < BAND_W'(TBL_DEPTH)) begin
                        tbl_we = 1'b1;
                    end
                end
            end
            F_SCAN: begin
                if (!emit) begin
                    state_next = F_IDLE;
                end else if (!job_full) begin
                    job_push  = 1'b1;
                    band_next = band_reg + BAND_W'(1);
                    if (!band_empty) begin
                        sum_next   = '0;
                        start_next = pos_reg;
                    end
                    // frame done: back to bin zero
                    if (band_last) begin
                        pos_next   = '0;
                        band_next  = '0;
                        start_next = '0;
                        sum_next   = '0;
                        state_next = F_IDLE;
                    end
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= F_IDLE;
            frame_size_reg   <= FS_W'(MAX_FRAME);
            bucket_count_reg <= BC_W'(MAX_BANDS);
            pos_reg          <= '0;
            band_reg         <= '0;
            start_reg        <= '0;
            sum_reg          <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            band_reg  <= band_next;
            start_reg <= start_next;
            sum_reg   <= sum_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_FRAME_SIZE:   frame_size_reg   <= cfg_data[FS_W-1:0];
                    CFG_BUCKET_COUNT: bucket_count_reg <= cfg_data[BC_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // boundary table; the user must load it before use, the block itself does not enforce this
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            boundary_reg[s_entry[TIDX_W-1:0]] <= s_boundary;
        end
    end

endmodule

>>> sv/sba_back.sv
// Back end: bit-serial divider for band means and the output register.
module sba_back #(
    parameter int MAX_BANDS    = 16,
    parameter int MAX_FRAME    = 1024,
    parameter int SAMPLE_WIDTH = 16,
    localparam int BAND_W = $clog2(MAX_BANDS),
    localparam int FS_W   = $clog2(MAX_FRAME + 1),
    localparam int SUM_W  = SAMPLE_WIDTH + FS_W
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // band jobs from the queue
    input  logic                           job_valid,
    output logic                           job_pop,
    input  logic [BAND_W-1:0]              job_band,
    input  logic signed [SUM_W-1:0]        job_sum,
    input  logic [FS_W-1:0]                job_count,
    input  logic                           job_empty,
    input  logic                           job_last,
    // result items
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [BAND_W-1:0]              m_band,
    output logic signed [SAMPLE_WIDTH-1:0] m_avg,
    output logic                           m_empty,
    output logic                           m_last
);
    import sba_pkg::*;

    localparam int CNT_W = $clog2(SAMPLE_WIDTH);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_DONE = 3'b100
    } back_state_t;

    back_state_t              state_reg, state_next;
    logic                     m_valid_reg, m_valid_next;
    logic [FS_W-1:0]          rem_reg;
    logic [SAMPLE_WIDTH-1:0]  dvd_reg;
    logic [FS_W-1:0]          divisor_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     neg_reg;
    logic [BAND_W-1:0]        band_reg;
    logic                     empty_reg;
    logic                     last_reg;
    logic [BAND_W-1:0]        m_band_reg;
    logic [SAMPLE_WIDTH-1:0]  m_avg_reg;
    logic                     m_empty_reg;
    logic                     m_last_reg;

    logic [SUM_W-1:0]         mag;
    logic [FS_W:0]            trial;
    logic                     ge;
    logic [FS_W:0]            diff;
    logic                     out_free, load_out;

    // magnitude of the band sum; quotient always fits the sample width
    assign mag = job_sum[SUM_W-1] ? SUM_W'(-job_sum) : SUM_W'(job_sum);

    // one restoring-division step
    assign trial = {rem_reg, dvd_reg[SAMPLE_WIDTH-1]};
    assign ge    = (trial >= {1'b0, divisor_reg});
    assign diff  = trial - {1'b0, divisor_reg};

    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == B_DONE) && out_free;
    assign job_pop  = (state_reg == B_IDLE) && job_valid;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (job_valid) state_next = job_empty ? B_DONE : B_DIV;
            B_DIV:  if (cnt_reg == '0) state_next = B_DONE;
            B_DONE: if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // divider datapath
    always_ff @(posedge aclk) begin
        if (job_pop) begin
            rem_reg     <= job_empty ? '0 : mag[SUM_W-1 -: FS_W];
            dvd_reg     <= job_empty ? '0 : mag[SAMPLE_WIDTH-1:0];
            divisor_reg <= job_count;
            cnt_reg     <= CNT_W'(SAMPLE_WIDTH - 1);
            neg_reg     <= !job_empty && job_sum[SUM_W-1];
            band_reg    <= job_band;
            empty_reg   <= job_empty;
            last_reg    <= job_last;
        end else if (state_reg == B_DIV) begin
            rem_reg <= ge ? diff[FS_W-1:0] : trial[FS_W-1:0];
            dvd_reg <= {dvd_reg[SAMPLE_WIDTH-2:0], ge};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // output register; quotient truncates toward zero, sign applied last
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_band_reg  <= band_reg;
            m_avg_reg   <= neg_reg ? (-dvd_reg) : dvd_reg;
            m_empty_reg <= empty_reg;
            m_last_reg  <= last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_band  = m_band_reg;
    assign m_avg   = m_avg_reg;
    assign m_empty = m_empty_reg;
    assign m_last  = m_last_reg;

endmodule

>>> sv/spectrum_band_averager.sv
// Spectrum band averager: top level tying front end, job queue and divider back end.
//
// Input stream s_axis: tuser 0 loads boundary entry entry_index (bands other than the
// last end before that bin), tuser 1 pushes one spectrum bin, in bin order.
// Config channel cfg_*: index 0 frame_size, index 1 bucket_count; cfg_ready is always high.
// Output stream m_axis: one item per finished band, tuser flags an empty band (mean 0),
// tlast marks the last band of the frame.
// Flow: a load leaves the input ready; a push moves the front end into its band check
// state, where it completes each band that is due and then returns to idle. Each
// non-empty band then passes the idle, divide and done states of the bit-serial divider,
// an empty band skips the divide state; the divider sets the band rate.
// A 4-entry job queue sits between the band detector and the divider; when it fills,
// s_axis_tready stays low until the divider frees an entry.
// A completed band travels from the band check state through the queue, the divider and
// the output register to m_axis_tvalid.
// Reset: frame state clears, frame_size = MAX_FRAME, bucket_count = MAX_BANDS; the
// boundary table is not cleared and must be loaded before use.
// Stall: a result waits in the output register while m_axis_tready is low; the divider
// finishes its current band and then waits, while the queue keeps filling behind it.
module spectrum_band_averager #(
    parameter int MAX_BANDS    = 16,
    parameter int MAX_FRAME    = 1024,
    parameter int SAMPLE_WIDTH = 16,
    localparam int BAND_W     = $clog2(MAX_BANDS),
    localparam int FS_W       = $clog2(MAX_FRAME + 1),
    localparam int BC_W       = $clog2(MAX_BANDS + 1),
    localparam int CFG_W      = (FS_W > BC_W) ? FS_W : BC_W,
    localparam int IN_DATA_W  = sba_pkg::byte_round(BAND_W + FS_W + SAMPLE_WIDTH),
    localparam int OUT_DATA_W = sba_pkg::byte_round(BAND_W + SAMPLE_WIDTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    // input items
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [IN_DATA_W-1:0]          s_axis_tdata,  // entry_index, boundary_value, sample
    input  logic                          s_axis_tuser,  // action
    // result items
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [OUT_DATA_W-1:0]         m_axis_tdata,  // band_number, band_average
    output logic                          m_axis_tuser,  // band_empty
    output logic                          m_axis_tlast   // frame_last
);
    import sba_pkg::*;

    localparam int SUM_W = SAMPLE_WIDTH + FS_W;
    localparam int JOB_W = BAND_W + SUM_W + FS_W + 2;

    logic [BAND_W-1:0]              s_entry;
    logic [FS_W-1:0]                s_boundary;
    logic signed [SAMPLE_WIDTH-1:0] s_sample;

    logic                    job_push, job_full, job_pop, job_qempty;
    logic [BAND_W-1:0]       fj_band, bj_band;
    logic signed [SUM_W-1:0] fj_sum, bj_sum;
    logic [FS_W-1:0]         fj_count, bj_count;
    logic                    fj_empty, bj_empty, fj_last, bj_last;
    logic [JOB_W-1:0]        job_wr, job_rd;

    logic [BAND_W-1:0]              m_band;
    logic signed [SAMPLE_WIDTH-1:0] m_avg;

    // unpack input item
    assign s_entry    = s_axis_tdata[BAND_W-1:0];
    assign s_boundary = s_axis_tdata[BAND_W +: FS_W];
    assign s_sample   = s_axis_tdata[BAND_W + FS_W +: SAMPLE_WIDTH];

    sba_front #(
        .MAX_BANDS    (MAX_BANDS),
        .MAX_FRAME    (MAX_FRAME),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_action   (s_axis_tuser),
        .s_entry    (s_entry),
        .s_boundary (s_boundary),
        .s_sample   (s_sample),
        .job_push   (job_push),
        .job_full   (job_full),
        .job_band   (fj_band),
        .job_sum    (fj_sum),
        .job_count  (fj_count),
        .job_empty  (fj_empty),
        .job_last   (fj_last)
    );

    // band jobs travel packed through the queue
    assign job_wr = {fj_band, fj_sum, fj_count, fj_empty, fj_last};
    assign {bj_band, bj_sum, bj_count, bj_empty, bj_last} = job_rd;

    sba_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (job_push),
        .wr_data (job_wr),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_rd),
        .empty   (job_qempty)
    );

    sba_back #(
        .MAX_BANDS    (MAX_BANDS),
        .MAX_FRAME    (MAX_FRAME),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (!job_qempty),
        .job_pop   (job_pop),
        .job_band  (bj_band),
        .job_sum   (bj_sum),
        .job_count (bj_count),
        .job_empty (bj_empty),
        .job_last  (bj_last),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_band    (m_band),
        .m_avg     (m_avg),
        .m_empty   (m_axis_tuser),
        .m_last    (m_axis_tlast)
    );

    // pack result item
    assign m_axis_tdata = OUT_DATA_W'({m_avg, m_band});

endmodule

>>> sv/sba_checker.sv
// Port-level assertion checker for the band averager, bound to the top level.
`include "assert_macros.svh"

module sba_checker #(
    parameter int MAX_BANDS    = 16,
    parameter int SAMPLE_WIDTH = 16,
    localparam int BAND_W     = $clog2(MAX_BANDS),
    localparam int OUT_DATA_W = sba_pkg::byte_round(BAND_W + SAMPLE_WIDTH)
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser,
    input logic                  m_axis_tlast
);
    import sba_pkg::*;

    // a stalled result item holds
    `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result item changed while stalled")

    // an empty band reports a zero mean
    `ASSERT_NOW(a_empty_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[BAND_W +: SAMPLE_WIDTH] == '0, "empty band with non-zero mean")

    // a pushed bin is always followed by a band check cycle
    `ASSERT_NEXT(a_push_scan, s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_PUSH), !s_axis_tready, "input ready right after a push")

    // a table load never stalls the input
    `ASSERT_NEXT(a_load_ready, s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_LOAD), s_axis_tready, "input stalled after a load")

endmodule

bind spectrum_band_averager sba_checker #(
    .MAX_BANDS    (MAX_BANDS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_sba_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
